// ===== rtl/tsr_pkg.sv =====
// shared types, constants and controller/datapath interface for the timestamp responder
package tsr_pkg;

	localparam int MAX_PAYLOAD = 32;
	localparam logic [5:0] COUNT_CAP = (MAX_PAYLOAD > 63) ? 6'd63 : 6'(MAX_PAYLOAD);
	localparam logic [5:0] MIN_LEN = 6'd9;

	localparam logic [7:0] OPC_REQUEST = 8'h01;
	localparam logic [7:0] OPC_REPLY   = 8'h02;
	localparam logic [7:0] OPC_SET     = 8'h03;
	localparam logic [7:0] OPC_ACK     = 8'h04;

	localparam logic [4:0] REQ_LAST_IDX = 5'd24;
	localparam logic [4:0] SET_LAST_IDX = 5'd8;

	localparam int MUL_BITS = 30;
	localparam logic [MUL_BITS-1:0] NS_PER_S = 30'd1000000000;
	localparam logic [5:0] DIV_LAST = 6'd63;
	localparam logic [5:0] MUL_LAST = 6'(MUL_BITS - 1);

	localparam logic [31:0] FREQ_RESET = 32'd1000000000;
	localparam logic [0:0] REG_TICK_FREQUENCY = 1'b0;

	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic [7:0]  reply_byte;
		logic        reply_last;
		logic        synced_flag;
		logic [31:0] adjust_count;
	} out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_APPLY,
		ST_DIV1,
		ST_MUL1,
		ST_MUL2,
		ST_DIV2,
		ST_FIN,
		ST_SEND
	} state_t;

	typedef struct packed {
		logic tick_inc;
		logic byte_take;
		logic clear_dgram;
		logic apply_set;
		logic div_load_tick;
		logic div_load_prod;
		logic div_step;
		logic mul_step;
		logic mul_sel_rem;
		logic save_sec;
		logic cnt_clr;
		logic finish;
		logic idx_clr;
		logic idx_inc;
	} cmd_t;

	typedef struct packed {
		logic req_ok;
		logic set_ok;
		logic div_last;
		logic mul_last;
		logic reply_last;
	} sts_t;

endpackage

// ===== rtl/tsr_ctrl.sv =====
// controller state machine sequencing byte intake, time conversion and reply output
module tsr_ctrl import tsr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   item_valid,
	input  in_t    item,
	output logic   item_ready,
	output logic   reply_valid,
	input  logic   reply_ready,
	input  sts_t   sts,
	output cmd_t   cmd
);

	state_t state_q, state_d;
	logic take;

	assign take = item_valid && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take && item.command && item.last_byte) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.req_ok) state_d = ST_DIV1;
				else if (sts.set_ok) state_d = ST_APPLY;
				else state_d = ST_IDLE;
			end
			ST_APPLY: state_d = ST_DIV1;
			ST_DIV1: begin
				if (sts.div_last) state_d = ST_MUL1;
			end
			ST_MUL1: begin
				if (sts.mul_last) state_d = ST_MUL2;
			end
			ST_MUL2: begin
				if (sts.mul_last) state_d = ST_DIV2;
			end
			ST_DIV2: begin
				if (sts.div_last) state_d = ST_FIN;
			end
			ST_FIN: state_d = ST_SEND;
			ST_SEND: begin
				if (reply_ready && sts.reply_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		item_ready = 1'b0;
		reply_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				cmd.tick_inc = take && !item.command;
				cmd.byte_take = take && item.command;
			end
			ST_CHECK: begin
				if (sts.req_ok) begin
					cmd.div_load_tick = 1'b1;
					cmd.cnt_clr = 1'b1;
				end else if (!sts.set_ok) begin
					cmd.clear_dgram = 1'b1;
				end
			end
			ST_APPLY: begin
				// offset moves before the time is taken
				cmd.apply_set = 1'b1;
				cmd.div_load_tick = 1'b1;
				cmd.cnt_clr = 1'b1;
			end
			ST_DIV1: begin
				cmd.div_step = 1'b1;
				cmd.cnt_clr = sts.div_last;
			end
			ST_MUL1: begin
				cmd.mul_step = 1'b1;
				cmd.save_sec = sts.mul_last;
				cmd.cnt_clr = sts.mul_last;
			end
			ST_MUL2: begin
				cmd.mul_step = 1'b1;
				cmd.mul_sel_rem = 1'b1;
				cmd.div_load_prod = sts.mul_last;
				cmd.cnt_clr = sts.mul_last;
			end
			ST_DIV2: begin
				cmd.div_step = 1'b1;
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				cmd.idx_clr = 1'b1;
			end
			ST_SEND: begin
				reply_valid = 1'b1;
				cmd.idx_inc = reply_ready && !sts.reply_last;
				cmd.clear_dgram = reply_ready && sts.reply_last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== rtl/tsr_dpath.sv =====
// datapath: tick count, datagram fields, shared divider and shift-add multiplier, reply bytes
module tsr_dpath import tsr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  in_t         item,
	input  logic [31:0] freq,
	input  cmd_t        cmd,
	output sts_t        sts,
	output out_t        reply
);

	logic [63:0] tick_q;
	logic [63:0] offset_q;
	logic        synced_q;
	logic [31:0] count_q;
	logic [5:0]  seen_q;
	logic [7:0]  opcode_q;
	logic [63:0] field_q;

	logic [63:0] quo_q;
	logic [31:0] rem_q;
	logic [63:0] acc_q;
	logic [63:0] sec_q;
	logic [63:0] now_q;
	logic [5:0]  cnt_q;
	logic [4:0]  idx_q;

	logic [32:0] rem_sh;
	logic [33:0] diff;
	logic        ge;
	logic [4:0]  mul_bit;
	logic [63:0] mul_op;
	logic [63:0] acc_next;
	logic [63:0] sel64;
	logic [2:0]  byte_pos;
	logic [4:0]  idx_m1;
	logic        is_set;

	// restoring division, one quotient bit per cycle
	assign rem_sh = {rem_q, quo_q[63]};
	assign diff = {1'b0, rem_sh} - {2'b00, freq};
	assign ge = !diff[33];

	// shift-add by the nanoseconds-per-second constant, msb first
	assign mul_bit = 5'(MUL_BITS - 1) - cnt_q[4:0];
	assign mul_op = cmd.mul_sel_rem ? {32'd0, rem_q} : quo_q;
	assign acc_next = {acc_q[62:0], 1'b0} + (NS_PER_S[mul_bit] ? mul_op : 64'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			offset_q <= '0;
			synced_q <= 1'b0;
			count_q <= '0;
			seen_q <= '0;
			opcode_q <= '0;
			field_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.tick_inc) tick_q <= tick_q + 64'd1;
			if (cmd.byte_take && (seen_q < COUNT_CAP)) begin
				if (seen_q == 6'd0) opcode_q <= item.data_byte;
				else if (seen_q < MIN_LEN) field_q <= {field_q[55:0], item.data_byte};
				seen_q <= seen_q + 6'd1;
			end
			if (cmd.clear_dgram) begin
				seen_q <= '0;
				opcode_q <= '0;
				field_q <= '0;
			end
			if (cmd.apply_set) begin
				offset_q <= offset_q + field_q;
				synced_q <= 1'b1;
				count_q <= count_q + 32'd1;
			end
			if (cmd.cnt_clr) cnt_q <= '0;
			else if (cmd.div_step || cmd.mul_step) cnt_q <= cnt_q + 6'd1;
			if (cmd.idx_clr) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load_tick) begin
			quo_q <= tick_q;
			rem_q <= '0;
		end else if (cmd.div_load_prod) begin
			quo_q <= acc_next;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[62:0], ge};
			rem_q <= ge ? diff[31:0] : rem_sh[31:0];
		end
		if (cmd.save_sec || cmd.div_load_tick) acc_q <= '0;
		else if (cmd.mul_step) acc_q <= acc_next;
		if (cmd.save_sec) sec_q <= acc_next;
		if (cmd.finish) now_q <= (freq == 32'd0) ? offset_q : sec_q + quo_q + offset_q;
	end

	assign is_set = (opcode_q == OPC_SET);
	assign idx_m1 = idx_q - 5'd1;
	assign byte_pos = idx_m1[2:0];
	assign sel64 = (!is_set && idx_q <= 5'd8) ? field_q : now_q;

	always_comb begin
		sts.req_ok = (seen_q >= MIN_LEN) && (opcode_q == OPC_REQUEST);
		sts.set_ok = (seen_q >= MIN_LEN) && is_set;
		sts.div_last = (cnt_q == DIV_LAST);
		sts.mul_last = (cnt_q == MUL_LAST);
		sts.reply_last = (idx_q == (is_set ? SET_LAST_IDX : REQ_LAST_IDX));

		if (idx_q == 5'd0) reply.reply_byte = is_set ? OPC_ACK : OPC_REPLY;
		else reply.reply_byte = 8'(sel64 >> (6'd56 - {byte_pos, 3'b000}));
		reply.reply_last = sts.reply_last;
		reply.synced_flag = synced_q;
		reply.adjust_count = count_q;
	end

endmodule

// ===== rtl/time_sync_timestamp_responder.sv =====
// Timestamp responder: keeps a tick count and a nanosecond offset and answers
// time requests and offset-set datagrams with big-endian reply bytes.
// The item channel (item_valid/item_ready/item) carries either one counter
// tick or one datagram payload byte; last_byte marks the end of a datagram.
// The reply channel (reply_valid/reply_ready/reply) carries one reply byte per
// transaction together with the synced flag and the adjustment count.
// A tick or a non-final byte is taken whenever the block is idle. On the final
// byte of a valid request or set-offset datagram the block converts ticks to
// nanoseconds with one shared one-bit-per-cycle divider (used twice) and a
// shift-add multiplier (used twice), then sends one reply byte per cycle while
// the receiver takes them (25 or 9 bytes). A final byte that gets no reply
// blocks input while its datagram is checked.
// Input is not taken while a datagram is converted or its reply is sent.
// If the receiver stalls, the current reply byte holds until it is taken.
// Reset clears the count, the offset, the sync state and any partial datagram;
// tick_frequency returns to 1e9 and is written through the APB port at 0x0.
module time_sync_timestamp_responder import tsr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  in_t         item,
	output logic        reply_valid,
	input  logic        reply_ready,
	output out_t        reply,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [31:0] freq_q;
	cmd_t cmd;
	sts_t sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= FREQ_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_TICK_FREQUENCY)) begin
			freq_q <= pwdata;
		end
	end

	assign prdata = (paddr[2] == REG_TICK_FREQUENCY) ? freq_q : 32'd0;

	tsr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item        (item),
		.item_ready  (item_ready),
		.reply_valid (reply_valid),
		.reply_ready (reply_ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	tsr_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.freq   (freq_q),
		.cmd    (cmd),
		.sts    (sts),
		.reply  (reply)
	);

endmodule

// ===== tb/sv/time_sync_timestamp_responder_test.sv =====
// testbench for the timestamp responder: random and directed datagrams checked against a predictor
module time_sync_timestamp_responder_test import tsr_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] ADDR_TICK_FREQUENCY = {REG_TICK_FREQUENCY, 2'b00};
	localparam logic [7:0] OPC_UNKNOWN = 8'h55;
	localparam int CONV_LATENCY = 260;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	in_t         item;
	logic        reply_valid;
	logic        reply_ready;
	out_t        reply;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	time_sync_timestamp_responder uut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.reply_valid(reply_valid), .reply_ready(reply_ready), .reply(reply),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	logic [31:0] freq_hz;
	logic [63:0] ticks;
	logic [63:0] offset;
	logic        in_sync;
	logic [31:0] adjustments;
	logic [5:0]  dgram_len;
	logic [7:0]  dgram_opcode;
	logic [63:0] dgram_field;

	out_t expected_bytes[$];
	int   failures;
	bit   send_idle_on;
	bit   recv_idle_on;
	int   hold_off;

	initial clk = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#200ms;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [63:0] ticks_to_ns();
		logic [63:0] f;
		logic [63:0] secs;
		logic [63:0] frac;
		f = {32'd0, freq_hz};
		if (f == 64'd0)
			return 64'd0;
		secs = ticks / f;
		frac = ticks % f;
		return secs * 64'd1000000000 + (frac * 64'd1000000000) / f;
	endfunction

	function automatic void push_reply_byte(logic [7:0] b, logic last);
		out_t r;
		r.reply_byte   = b;
		r.reply_last   = last;
		r.synced_flag  = in_sync;
		r.adjust_count = adjustments;
		expected_bytes.push_back(r);
	endfunction

	function automatic void push_word(logic [63:0] v, logic last_word);
		for (int i = 0; i < 8; i++)
			push_reply_byte(v[63 - 8 * i -: 8], last_word && i == 7);
	endfunction

	function automatic void predict_item(in_t it);
		logic [63:0] now;
		if (!it.command) begin
			ticks++;
			return;
		end
		if (dgram_len < COUNT_CAP) begin
			if (dgram_len == 6'd0)
				dgram_opcode = it.data_byte;
			else if (dgram_len < MIN_LEN)
				dgram_field = {dgram_field[55:0], it.data_byte};
			dgram_len++;
		end
		if (!it.last_byte)
			return;
		if (dgram_len >= MIN_LEN) begin
			if (dgram_opcode == OPC_REQUEST) begin
				now = ticks_to_ns() + offset;
				push_reply_byte(OPC_REPLY, 1'b0);
				push_word(dgram_field, 1'b0);
				push_word(now, 1'b0);
				push_word(now, 1'b1);
			end else if (dgram_opcode == OPC_SET) begin
				offset += dgram_field;
				in_sync = 1'b1;
				adjustments++;
				now = ticks_to_ns() + offset;
				push_reply_byte(OPC_ACK, 1'b0);
				push_word(now, 1'b1);
			end
		end
		dgram_len = '0;
		dgram_opcode = '0;
		dgram_field = '0;
	endfunction

	// reply checker and receiver stall
	always @(posedge clk) begin
		out_t exp_r;
		if (arst_n && reply_valid && reply_ready) begin
			if (expected_bytes.size() == 0) begin
				$error("unexpected reply transaction %h", reply);
				failures++;
			end else begin
				exp_r = expected_bytes.pop_front();
				if (reply.reply_byte !== exp_r.reply_byte) begin
					$error("reply_byte expected %h actual %h", exp_r.reply_byte, reply.reply_byte);
					failures++;
				end
				if (reply.reply_last !== exp_r.reply_last) begin
					$error("reply_last expected %b actual %b", exp_r.reply_last, reply.reply_last);
					failures++;
				end
				if (reply.synced_flag !== exp_r.synced_flag) begin
					$error("synced_flag expected %b actual %b",
						exp_r.synced_flag, reply.synced_flag);
					failures++;
				end
				if (reply.adjust_count !== exp_r.adjust_count) begin
					$error("adjust_count expected %h actual %h",
						exp_r.adjust_count, reply.adjust_count);
					failures++;
				end
			end
		end
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			reply_ready <= 1'b0;
		end else begin
			reply_ready <= !(recv_idle_on && $urandom_range(99) < 9);
		end
	end

	// valid stays high from one transaction to the next unless an idle gap is inserted; drain() drops it
	task automatic send_item(logic cmd, logic [7:0] b, logic last);
		in_t it;
		while (send_idle_on && $urandom_range(99) < 9) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		it.command = cmd;
		it.data_byte = b;
		it.last_byte = last;
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		predict_item(it);
	endtask

	task automatic send_dgram(logic [7:0] opc, logic [63:0] field, int len);
		for (int i = 0; i < len; i++) begin
			if (i == 0)
				send_item(1'b1, opc, len == 1);
			else if (i < 9)
				send_item(1'b1, field[63 - 8 * (i - 1) -: 8], i == len - 1);
			else
				send_item(1'b1, 8'($urandom), i == len - 1);
		end
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		item_valid <= 1'b0;
		while (expected_bytes.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (CONV_LATENCY) @(posedge clk);
	endtask

	task automatic write_freq(logic [31:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ADDR_TICK_FREQUENCY;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		freq_hz = v;
	endtask

	task automatic test_directed();
		send_dgram(OPC_REQUEST, 64'h0123_4567_89ab_cdef, 9);
		send_item(1'b0, 8'hff, 1'b1);
		send_item(1'b0, 8'h00, 1'b0);
		send_dgram(OPC_SET, 64'hffff_ffff_ffff_ff00, 9);
		// tick in the middle of a request
		send_item(1'b1, OPC_REQUEST, 1'b0);
		send_item(1'b0, 8'haa, 1'b0);
		for (int i = 0; i < 8; i++)
			send_item(1'b1, 8'hff, i == 7);
		send_dgram(OPC_UNKNOWN, 64'h5555_5555_5555_5555, 9);
		send_dgram(OPC_REQUEST, 64'd0, 5);
		drain();
	endtask

	task automatic test_freq_extremes();
		write_freq(32'd0);
		send_dgram(OPC_SET, 64'h8000_0000_0000_0000, 9);
		send_dgram(OPC_REQUEST, 64'h1, 40);
		drain();
		write_freq(32'hffff_ffff);
		repeat (3) send_item(1'b0, 8'h00, 1'b0);
		send_dgram(OPC_REQUEST, 64'h2, 10);
		drain();
		write_freq(32'd1);
		send_dgram(OPC_REQUEST, 64'h3, 9);
		drain();
	endtask

	task automatic test_backpressure();
		hold_off = 300;
		send_dgram(OPC_REQUEST, {$urandom, $urandom}, 9);
		send_dgram(OPC_SET, {$urandom, $urandom}, 9);
		send_dgram(OPC_REQUEST, {$urandom, $urandom}, 9);
		drain();
	endtask

	task automatic test_random(int n_items);
		int sent;
		int len;
		int kind;
		sent = 0;
		while (sent < n_items) begin
			// no idling on either side through the middle stretch
			if (sent >= n_items / 3 && sent <= n_items / 2) begin
				send_idle_on = 1'b0;
				recv_idle_on = 1'b0;
			end
			if (sent > n_items / 2) begin
				send_idle_on = 1'b1;
				recv_idle_on = 1'b1;
			end
			kind = $urandom_range(9);
			if (kind < 2) begin
				send_item(1'b0, 8'($urandom), 1'($urandom));
				sent++;
			end else begin
				len = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(9, 12);
				send_dgram(kind < 6 ? OPC_REQUEST : (kind < 9 ? OPC_SET : 8'($urandom)),
					{$urandom, $urandom}, len);
				sent += len;
			end
			if ($urandom_range(19) == 0) begin
				drain();
				write_freq($urandom_range(3) == 0 ? $urandom : $urandom_range(1, 1000));
			end
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		reply_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		failures = 0;
		hold_off = 0;
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
		freq_hz = FREQ_RESET;
		ticks = '0;
		offset = '0;
		in_sync = 1'b0;
		adjustments = '0;
		dgram_len = '0;
		dgram_opcode = '0;
		dgram_field = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_freq_extremes();
		test_backpressure();
		write_freq(FREQ_RESET);
		test_random(110);
		if (failures == 0 && expected_bytes.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/tsr_pkg.sv
rtl/tsr_ctrl.sv
rtl/tsr_dpath.sv
rtl/time_sync_timestamp_responder.sv
tb/sv/time_sync_timestamp_responder_test.sv
